// File: design/lrupr_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and sequencer states of the LRU page replacement core.
package lrupr_pkg;

    localparam int FRAMES      = 16;
    localparam int PAGE_BITS   = 16;
    localparam int SLOT_BITS   = $clog2(FRAMES);
    localparam int RANK_BITS   = $clog2(FRAMES);
    localparam int FC_BITS     = 5;
    localparam int TOTAL_BITS  = 32;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam logic [FC_BITS-1:0] FC_RESET = FC_BITS'(16);

    // One page request as held in the front queue
    typedef struct packed {
        logic [PAGE_BITS-1:0] page;
        logic                 last_reference;
    } req_t;

    // Lookup outcome handed from the lookup step to the commit step
    typedef struct packed {
        logic                 hit;
        logic                 evict;
        logic [SLOT_BITS-1:0] slot;
        logic [PAGE_BITS-1:0] evicted_page;
    } cls_t;

    typedef enum logic {
        ENG_LOOK,
        ENG_COMMIT
    } eng_state_t;

endpackage

// File: design/lrupr_if.sv
`timescale 1ns / 1ps
// Request and response channel interfaces of the LRU page replacement core.
interface lrupr_req_if;
    logic                           valid;
    logic                           ready;
    logic [lrupr_pkg::PAGE_BITS-1:0] page;
    logic                           last_reference;

    modport source (output valid, output page, output last_reference, input ready);
    modport sink   (input valid, input page, input last_reference, output ready);
endinterface

interface lrupr_rsp_if;
    logic                            valid;
    logic                            ready;
    logic                            hit;
    logic [lrupr_pkg::SLOT_BITS-1:0]  slot;
    logic                            evicted_valid;
    logic [lrupr_pkg::PAGE_BITS-1:0]  evicted_page;
    logic [lrupr_pkg::TOTAL_BITS-1:0] hit_total;
    logic [lrupr_pkg::TOTAL_BITS-1:0] fault_total;
    logic                            string_done;

    modport source (output valid, output hit, output slot, output evicted_valid,
                    output evicted_page, output hit_total, output fault_total,
                    output string_done, input ready);
    modport sink   (input valid, input hit, input slot, input evicted_valid,
                    input evicted_page, input hit_total, input fault_total,
                    input string_done, output ready);
endinterface

// File: design/lrupr_front.sv
`timescale 1ns / 1ps
// Front end: accepts page requests into a short queue for the replacement engine.
module lrupr_front
(
    input  logic              clk,
    input  logic              rst_n,
    lrupr_req_if.sink         req,
    output logic              q_valid,
    output lrupr_pkg::req_t   q_head,
    input  logic              q_pop
);

    lrupr_pkg::req_t                  ent_reg [lrupr_pkg::QUEUE_DEPTH];
    logic [lrupr_pkg::QPTR_BITS-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [lrupr_pkg::QPTR_BITS-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [lrupr_pkg::QPTR_BITS:0]    count_reg, count_next;
    logic                             push;
    logic                             pop;

    assign req.ready = (count_reg != (lrupr_pkg::QPTR_BITS+1)'(lrupr_pkg::QUEUE_DEPTH));
    assign push      = req.valid && req.ready;
    assign q_valid   = (count_reg != '0);
    assign pop       = q_pop && q_valid;
    assign q_head    = ent_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // payload storage, no reset
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg].page           <= req.page;
            ent_reg[wr_ptr_reg].last_reference <= req.last_reference;
        end
    end

endmodule

// File: design/lrupr_back.sv
`timescale 1ns / 1ps
// Back end: frame store, lookup and commit sequencer, totals and response register.
module lrupr_back
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [lrupr_pkg::FC_BITS-1:0]   cfg_data,
    input  logic                            q_valid,
    input  lrupr_pkg::req_t                 q_head,
    output logic                            q_pop,
    lrupr_rsp_if.source                     rsp
);

    localparam int F  = lrupr_pkg::FRAMES;
    localparam int SB = lrupr_pkg::SLOT_BITS;
    localparam int RB = lrupr_pkg::RANK_BITS;
    localparam int PB = lrupr_pkg::PAGE_BITS;
    localparam int FB = lrupr_pkg::FC_BITS;
    localparam int TB = lrupr_pkg::TOTAL_BITS;

    // frame store
    logic [PB-1:0] page_reg  [F];
    logic [PB-1:0] page_next [F];
    logic [RB-1:0] rank_reg  [F];
    logic [RB-1:0] rank_next [F];
    logic [F-1:0]  valid_reg, valid_next;
    logic [FB-1:0] fc_reg, fc_next;
    logic [TB-1:0] hits_reg, hits_next;
    logic [TB-1:0] faults_reg, faults_next;

    // sequencer and step registers
    lrupr_pkg::eng_state_t state_reg, state_next;
    lrupr_pkg::req_t       cur_reg;
    lrupr_pkg::cls_t       cls_reg, cls_next;
    logic                  load_cls;
    logic                  commit;

    // response register
    logic          out_valid_reg, out_valid_next;
    logic          out_hit_reg;
    logic [SB-1:0] out_slot_reg;
    logic          out_evv_reg;
    logic [PB-1:0] out_evp_reg;
    logic [TB-1:0] out_hits_reg;
    logic [TB-1:0] out_faults_reg;
    logic          out_done_reg;

    // lookup
    logic [FB-1:0] used;
    logic [RB-1:0] used_m1;
    logic [F-1:0]  match_vec, free_vec, victim_vec;
    logic          hit_any, free_any;
    logic [SB-1:0] hit_slot, free_slot, victim_slot;

    assign used    = (fc_reg == '0) ? FB'(1) :
                     (fc_reg > FB'(F)) ? FB'(F) : fc_reg;
    assign used_m1 = RB'(used - FB'(1));

    always_comb
    begin
        hit_slot    = '0;
        free_slot   = '0;
        victim_slot = '0;
        for (int j = 0; j < F; j++)
        begin
            match_vec[j]  = valid_reg[j] && (page_reg[j] == q_head.page);
            free_vec[j]   = !valid_reg[j] && (FB'(j) < used);
            victim_vec[j] = valid_reg[j] && (rank_reg[j] == used_m1);
        end
        // lowest index wins
        for (int j = F - 1; j >= 0; j--)
        begin
            if (match_vec[j])
            begin
                hit_slot = SB'(j);
            end
            if (free_vec[j])
            begin
                free_slot = SB'(j);
            end
            if (victim_vec[j])
            begin
                victim_slot = SB'(j);
            end
        end
        hit_any  = |match_vec;
        free_any = |free_vec;

        cls_next.hit          = hit_any;
        cls_next.evict        = !hit_any && !free_any;
        cls_next.slot         = hit_any ? hit_slot : (free_any ? free_slot : victim_slot);
        cls_next.evicted_page = cls_next.evict ? page_reg[victim_slot] : '0;
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        load_cls   = 1'b0;
        commit     = 1'b0;
        case (state_reg)
            lrupr_pkg::ENG_LOOK:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    load_cls   = 1'b1;
                    state_next = lrupr_pkg::ENG_COMMIT;
                end
            end
            lrupr_pkg::ENG_COMMIT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    commit     = 1'b1;
                    state_next = lrupr_pkg::ENG_LOOK;
                end
            end
            default:
            begin
                state_next = lrupr_pkg::ENG_LOOK;
            end
        endcase
    end

    // store update
    always_comb
    begin
        page_next   = page_reg;
        rank_next   = rank_reg;
        valid_next  = valid_reg;
        fc_next     = fc_reg;
        hits_next   = hits_reg;
        faults_next = faults_reg;
        if (cfg_we)
        begin
            fc_next     = cfg_data;
            valid_next  = '0;
            rank_next   = '{default: '0};
            hits_next   = '0;
            faults_next = '0;
        end
        else if (commit)
        begin
            for (int j = 0; j < F; j++)
            begin
                if ((SB'(j) != cls_reg.slot) && valid_reg[j] &&
                    (!cls_reg.hit || (rank_reg[j] < rank_reg[cls_reg.slot])))
                begin
                    rank_next[j] = rank_reg[j] + 1'b1;
                end
            end
            rank_next[cls_reg.slot] = '0;
            if (cls_reg.hit)
            begin
                hits_next = (hits_reg == '1) ? hits_reg : hits_reg + TB'(1);
            end
            else
            begin
                page_next[cls_reg.slot]  = cur_reg.page;
                valid_next[cls_reg.slot] = 1'b1;
                faults_next = (faults_reg == '1) ? faults_reg : faults_reg + TB'(1);
            end
            if (cur_reg.last_reference)
            begin
                valid_next  = '0;
                rank_next   = '{default: '0};
                hits_next   = '0;
                faults_next = '0;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lrupr_pkg::ENG_LOOK;
            valid_reg     <= '0;
            rank_reg      <= '{default: '0};
            fc_reg        <= lrupr_pkg::FC_RESET;
            hits_reg      <= '0;
            faults_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            rank_reg      <= rank_next;
            fc_reg        <= fc_next;
            hits_reg      <= hits_next;
            faults_reg    <= faults_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        page_reg <= page_next;
        if (load_cls)
        begin
            cur_reg <= q_head;
            cls_reg <= cls_next;
        end
        if (commit)
        begin
            out_hit_reg    <= cls_reg.hit;
            out_slot_reg   <= cls_reg.slot;
            out_evv_reg    <= cls_reg.evict;
            out_evp_reg    <= cls_reg.evicted_page;
            out_done_reg   <= cur_reg.last_reference;
            out_hits_reg   <= cls_reg.hit ?
                              ((hits_reg == '1) ? hits_reg : hits_reg + TB'(1)) : hits_reg;
            out_faults_reg <= !cls_reg.hit ?
                              ((faults_reg == '1) ? faults_reg : faults_reg + TB'(1)) :
                              faults_reg;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.hit           = out_hit_reg;
    assign rsp.slot          = out_slot_reg;
    assign rsp.evicted_valid = out_evv_reg;
    assign rsp.evicted_page  = out_evp_reg;
    assign rsp.hit_total     = out_hits_reg;
    assign rsp.fault_total   = out_faults_reg;
    assign rsp.string_done   = out_done_reg;

endmodule

// File: design/lru_page_replacement_core.sv
`timescale 1ns / 1ps
// A request passes from the front queue into the lookup result registers and then,
// once the response register is free, into it. The back end takes one request at a time
// through its lookup then commit sequence and owns the single frame store.
// The front queue holds two requests, so intake continues while a response waits.
// Reset (async, active low): all frames empty, totals zero, frame_count 16, queue empty.
module lru_page_replacement_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [lrupr_pkg::FC_BITS-1:0] cfg_data,
    lrupr_req_if.sink                     req,
    lrupr_rsp_if.source                   rsp
);

    // front to back queue head
    logic            q_valid;
    lrupr_pkg::req_t q_head;
    logic            q_pop;

    // Front: two-entry request queue; decouples intake from the engine
    lrupr_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .q_valid (q_valid),
        .q_head  (q_head),
        .q_pop   (q_pop)
    );

    // Back: step one compares the head page against every frame in parallel and
    // picks hit slot, first empty slot or the LRU victim (rank frames-in-use minus
    // one, where frame_count 0 counts as one frame and above 16 as sixteen);
    // step two ages the ranks, writes the frame, bumps the saturating totals and
    // loads the response register. Last-of-string and config writes clear state.
    lrupr_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .q_valid  (q_valid),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .rsp      (rsp)
    );

`ifndef SYNTHESIS
    a_hit_counted: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.hit) |-> (rsp.hit_total != '0))
        else $error("hit response with zero hit total");

    a_fault_counted: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.hit) |-> (rsp.fault_total != '0))
        else $error("fault response with zero fault total");

    a_evict_on_fault: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.evicted_valid) |-> !rsp.hit)
        else $error("eviction reported on a hit");

    a_no_evict_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.evicted_valid) |-> (rsp.evicted_page == '0))
        else $error("evicted page non-zero without eviction");
`endif

endmodule
